[rtl/mgws_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgws_pkg
// Shared types and codes for the maze grid wall store.
// ----------------------------------------------------------------------------
package mgws_pkg;

    localparam int CFG_W       = 7;
    localparam int CELL_ADDR_W = 16;  // holds row * MAX_WIDTH + column up to 256 x 256

    localparam logic [1:0] ACT_OPEN  = 2'd0;
    localparam logic [1:0] ACT_QUERY = 2'd1;
    localparam logic [1:0] ACT_PLOT  = 2'd2;

    localparam logic [1:0] DIR_NORTH = 2'd0;
    localparam logic [1:0] DIR_EAST  = 2'd1;
    localparam logic [1:0] DIR_SOUTH = 2'd2;
    localparam logic [1:0] DIR_WEST  = 2'd3;

    localparam logic [1:0] PIX_WALL     = 2'd0;
    localparam logic [1:0] PIX_SPACE    = 2'd1;
    localparam logic [1:0] PIX_ENTRANCE = 2'd2;
    localparam logic [1:0] PIX_EXIT     = 2'd3;

    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    typedef struct packed {
        logic [1:0] action;
        logic [5:0] cell_x;
        logic [5:0] cell_y;
        logic [1:0] direction;
        logic [7:0] plot_x;
        logic [7:0] plot_y;
    } t_item;

    typedef struct packed {
        logic       path_open;
        logic [1:0] pixel;
        logic       out_of_range;
    } t_result;

    typedef enum logic [1:0] {
        OP_FIXED,
        OP_OPEN,
        OP_QUERY,
        OP_PIXEL
    } t_op;

    typedef struct packed {
        t_op                    op;
        logic [CELL_ADDR_W-1:0] addr;
        logic                   west;
        t_result                res;
    } t_cmd;

endpackage

[rtl/maze_grid_wall_store_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maze_grid_wall_store_top
// Maze cell store with open, query and plot-pixel transactions.
// ----------------------------------------------------------------------------
// After reset the passage memory is swept clear, one entry per cycle, over all
// MAX_WIDTH * MAX_HEIGHT entries; input stays stalled during the sweep, while
// configuration writes are taken at any time outside reset. A two-entry queue
// sits between classification and the memory. Open, range errors, edge cases
// and border pixels are loaded into the result register straight from the
// queue; query and inner plot pixels first pass through a read state for the
// registered read of the passage memory. Results wait in an output register,
// so input keeps flowing until the queue fills.
// ----------------------------------------------------------------------------
module maze_grid_wall_store_top
    import mgws_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_item            i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_result          o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic [CFG_W-1:0] r_width_cells, r_height_cells;
    t_cmd             front_cmd, q_cmd;
    logic             q_full, q_empty, q_pop, push, clearing;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_cells  <= CFG_W'(1);
            r_height_cells <= CFG_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IDX_WIDTH:  r_width_cells  <= i_cfg_data;
                CFG_IDX_HEIGHT: r_height_cells <= i_cfg_data;
                default: begin
                    r_width_cells <= r_width_cells;
                end
            endcase
        end
    end

    assign o_in_stall = q_full || clearing;
    assign push       = i_in_valid && !o_in_stall;

    mgws_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_item         (i_in_data),
        .i_width_cells  (r_width_cells),
        .i_height_cells (r_height_cells),
        .o_cmd          (front_cmd)
    );

    mgws_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    mgws_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_empty     (q_empty),
        .o_pop       (q_pop),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out_data)
    );

endmodule

[rtl/mgws_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgws_front
// Classifies a transaction: range checks, passage lookup, border pixel rules.
// ----------------------------------------------------------------------------
module mgws_front
    import mgws_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  t_item            i_item,
    input  logic [CFG_W-1:0] i_width_cells,
    input  logic [CFG_W-1:0] i_height_cells,
    output t_cmd             o_cmd
);

    localparam logic [8:0] MAX_W9 = 9'(MAX_WIDTH);
    localparam logic [8:0] MAX_H9 = 9'(MAX_HEIGHT);
    localparam logic [CELL_ADDR_W-1:0] ROW_STRIDE = CELL_ADDR_W'(MAX_WIDTH);

    function automatic logic [1:0] cell_kind(input logic [6:0] cx, input logic [6:0] cy,
                                             input logic [6:0] w, input logic [6:0] h);
        logic [1:0] k;
        if (cx == 7'd0 && cy == 7'd0) begin
            k = PIX_ENTRANCE;
        end else if (cx == w - 7'd1 && cy == h - 7'd1) begin
            k = PIX_EXIT;
        end else begin
            k = PIX_WALL;
        end
        return k;
    endfunction

    logic [8:0] w9, h9;
    logic [6:0] w, h;
    logic [6:0] cx, cy, tx, ty, px_tx, px_ty;
    logic       edge_hit, tgt_west, px_west;
    logic [7:0] x, y, pw_m1, ph_m1, xm1, xm2, ym1, ym2;
    logic       xo, yo;
    logic [1:0] pix;
    logic       pix_inner;

    always_comb begin
        w9 = (i_width_cells == '0) ? 9'd1 :
             ({2'b00, i_width_cells} > MAX_W9) ? MAX_W9 : {2'b00, i_width_cells};
        h9 = (i_height_cells == '0) ? 9'd1 :
             ({2'b00, i_height_cells} > MAX_H9) ? MAX_H9 : {2'b00, i_height_cells};
        w  = w9[6:0];
        h  = h9[6:0];
    end

    // open / query: locate the cell and bit that hold the passage
    always_comb begin
        cx       = {1'b0, i_item.cell_x};
        cy       = {1'b0, i_item.cell_y};
        tx       = cx;
        ty       = cy;
        tgt_west = 1'b0;
        edge_hit = 1'b0;
        case (i_item.direction)
            DIR_NORTH: begin
                edge_hit = (cy == 7'd0);
            end
            DIR_EAST: begin
                edge_hit = (cx + 7'd1 >= w);
                tx       = cx + 7'd1;
                tgt_west = 1'b1;
            end
            DIR_SOUTH: begin
                edge_hit = (cy + 7'd1 >= h);
                ty       = cy + 7'd1;
            end
            default: begin
                edge_hit = (cx == 7'd0);
                tgt_west = 1'b1;
            end
        endcase
    end

    // plot pixel
    always_comb begin
        x         = i_item.plot_x;
        y         = i_item.plot_y;
        pw_m1     = {w, 1'b0};
        ph_m1     = {h, 1'b0};
        xm1       = x - 8'd1;
        xm2       = x - 8'd2;
        ym1       = y - 8'd1;
        ym2       = y - 8'd2;
        xo        = x[0];
        yo        = y[0];
        pix       = PIX_WALL;
        pix_inner = 1'b0;
        px_west   = 1'b0;
        px_tx     = x[7:1];
        px_ty     = ym1[7:1];
        if (!xo && !yo) begin
            pix = PIX_WALL;
        end else if (xo && yo) begin
            pix = PIX_SPACE;
        end else if (y == 8'd0) begin
            pix = cell_kind(xm1[7:1], 7'd0, w, h);
        end else if (x == 8'd0) begin
            pix = (y != 8'd1) ? cell_kind(7'd0, ym1[7:1], w, h) : PIX_WALL;
        end else if (y == ph_m1) begin
            pix = cell_kind(xm1[7:1], ym2[7:1], w, h);
        end else if (x == pw_m1) begin
            pix = (y != ph_m1 - 8'd1) ? cell_kind(xm2[7:1], ym1[7:1], w, h) : PIX_WALL;
        end else if (xo) begin
            pix_inner = 1'b1;
            px_tx     = xm1[7:1];
            px_ty     = y[7:1];
        end else begin
            pix_inner = 1'b1;
            px_west   = 1'b1;
        end
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.op   = OP_FIXED;
        case (i_item.action)
            ACT_OPEN, ACT_QUERY: begin
                if ({1'b0, i_item.cell_x} >= w || {1'b0, i_item.cell_y} >= h) begin
                    o_cmd.res.out_of_range = 1'b1;
                end else if (!edge_hit) begin
                    o_cmd.op            = (i_item.action == ACT_OPEN) ? OP_OPEN : OP_QUERY;
                    o_cmd.addr          = CELL_ADDR_W'(ty) * ROW_STRIDE + CELL_ADDR_W'(tx);
                    o_cmd.west          = tgt_west;
                    o_cmd.res.path_open = (i_item.action == ACT_OPEN);
                end
            end
            ACT_PLOT: begin
                if (x > pw_m1 || y > ph_m1) begin
                    o_cmd.res.out_of_range = 1'b1;
                end else if (pix_inner) begin
                    o_cmd.op   = OP_PIXEL;
                    o_cmd.addr = CELL_ADDR_W'(px_ty) * ROW_STRIDE + CELL_ADDR_W'(px_tx);
                    o_cmd.west = px_west;
                end else begin
                    o_cmd.res.pixel = pix;
                end
            end
            default: begin
                o_cmd.op = OP_FIXED;
            end
        endcase
    end

endmodule

[rtl/mgws_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgws_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module mgws_queue
    import mgws_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    t_cmd       r_slot [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count;

    assign o_cmd   = r_slot[r_rd];
    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

endmodule

[rtl/mgws_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgws_back
// Passage memory, clearing sweep after reset and the result register.
// ----------------------------------------------------------------------------
module mgws_back
    import mgws_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  logic    i_empty,
    output logic    o_pop,
    output logic    o_clearing,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_out
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_RUN,
        S_READ
    } t_state;

    t_state          r_state;
    logic [AW-1:0]   r_clr_addr;
    logic            r_out_valid;
    t_result         r_out;
    logic            r_sel_west, r_sel_pix;
    logic            r_rd_north, r_rd_west;
    logic            r_mem_north [DEPTH];
    logic            r_mem_west  [DEPTH];

    logic            out_free, is_read, rd_en, wr_en, wr_north, wr_west, wr_bit, rd_bit;
    logic            out_load;
    logic [AW-1:0]   cmd_addr, wr_addr;
    t_result         rd_res;

    always_comb begin
        out_free = !r_out_valid || !i_out_stall;
        cmd_addr = i_cmd.addr[AW-1:0];
        is_read  = (i_cmd.op == OP_QUERY) || (i_cmd.op == OP_PIXEL);
        o_pop    = (r_state == S_RUN) && !i_empty && (out_free || is_read);
        rd_en    = o_pop && is_read;
        out_load = (o_pop && !is_read) || ((r_state == S_READ) && out_free);
        if (r_state == S_CLEAR) begin
            wr_en    = 1'b1;
            wr_addr  = r_clr_addr;
            wr_bit   = 1'b0;
            wr_north = 1'b1;
            wr_west  = 1'b1;
        end else begin
            wr_en    = o_pop && (i_cmd.op == OP_OPEN);
            wr_addr  = cmd_addr;
            wr_bit   = 1'b1;
            wr_north = !i_cmd.west;
            wr_west  = i_cmd.west;
        end
        rd_bit = r_sel_west ? r_rd_west : r_rd_north;
        rd_res = '0;
        if (r_sel_pix) begin
            rd_res.pixel = rd_bit ? PIX_SPACE : PIX_WALL;
        end else begin
            rd_res.path_open = rd_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && wr_north) begin
            r_mem_north[wr_addr] <= wr_bit;
        end
        if (rd_en) begin
            r_rd_north <= r_mem_north[cmd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && wr_west) begin
            r_mem_west[wr_addr] <= wr_bit;
        end
        if (rd_en) begin
            r_rd_west <= r_mem_west[cmd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && !out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == LAST_ADDR) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (o_pop) begin
                        if (is_read) begin
                            r_sel_west <= i_cmd.west;
                            r_sel_pix  <= (i_cmd.op == OP_PIXEL);
                            r_state    <= S_READ;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_out       <= i_cmd.res;
                        end
                    end
                end
                S_READ: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out       <= rd_res;
                        r_state     <= S_RUN;
                    end
                end
                default: begin
                    r_state <= S_RUN;
                end
            endcase
        end
    end

    assign o_clearing  = (r_state == S_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[verif/maze_grid_wall_store_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maze_grid_wall_store_top_test
// Self-checking bench for the maze cell store.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of the passage store and the grid size
// and predicts the result of every accepted transaction. A short directed set
// covers edge passages, border pixels, entrance and exit, out-of-range
// coordinates, the unknown action and the size clamps. Random phases then run
// open, query and plot transactions on grids of several sizes. The sender
// works in bursts with gaps, and the result side stalls on its own pattern.
// ----------------------------------------------------------------------------
module maze_grid_wall_store_top_test;
    import mgws_pkg::*;

    localparam int GRID_COLS      = 64;
    localparam int GRID_ROWS      = 64;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_ITEMS    = 60;
    localparam int NUM_PHASES     = 10;

    localparam logic [1:0] ACT_UNKNOWN = 2'd3;
    localparam logic [1:0] NORTH_BIT   = 2'b01;
    localparam logic [1:0] WEST_BIT    = 2'b10;

    class passage_scoreboard;
        logic [1:0]       passage_mem [0:GRID_COLS*GRID_ROWS-1];
        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] height_reg;
        t_result          pending_results [$];
        int               errors;

        function new();
            foreach (passage_mem[i]) passage_mem[i] = 2'b00;
            width_reg  = 1;
            height_reg = 1;
            errors     = 0;
        endfunction

        function int unsigned clamp_size(logic [CFG_W-1:0] r, int unsigned lim);
            if (r == 0) return 1;
            return (r > lim) ? lim : r;
        endfunction

        function int unsigned cols();
            return clamp_size(width_reg, GRID_COLS);
        endfunction

        function int unsigned rows();
            return clamp_size(height_reg, GRID_ROWS);
        endfunction

        function void write_size(logic idx, logic [CFG_W-1:0] val);
            if (idx == CFG_IDX_WIDTH) width_reg = val;
            else height_reg = val;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function logic [1:0] border_kind(int unsigned cx, int unsigned cy,
                                         int unsigned w, int unsigned h);
            if (cx == 0 && cy == 0) return PIX_ENTRANCE;
            if (cx == w - 1 && cy == h - 1) return PIX_EXIT;
            return PIX_WALL;
        endfunction

        function logic [1:0] pixel_at(int unsigned x, int unsigned y,
                                      int unsigned w, int unsigned h);
            int unsigned pw;
            int unsigned ph;
            pw = 2 * w + 1;
            ph = 2 * h + 1;
            if (!x[0] && !y[0]) return PIX_WALL;
            if (x[0] && y[0]) return PIX_SPACE;
            if (y == 0) return border_kind((x - 1) / 2, 0, w, h);
            if (x == 0) return (y != 1) ? border_kind(0, (y - 1) / 2, w, h) : PIX_WALL;
            if (y == ph - 1) return border_kind((x - 1) / 2, (y - 2) / 2, w, h);
            if (x == pw - 1)
                return (y != ph - 2) ? border_kind((x - 2) / 2, (y - 1) / 2, w, h) : PIX_WALL;
            // inner gap: horizontal wall uses the north bit, vertical the west bit
            if (x[0])
                return ((passage_mem[(y / 2) * GRID_COLS + (x - 1) / 2] & NORTH_BIT) != 0) ?
                       PIX_SPACE : PIX_WALL;
            return ((passage_mem[((y - 1) / 2) * GRID_COLS + x / 2] & WEST_BIT) != 0) ?
                   PIX_SPACE : PIX_WALL;
        endfunction

        function t_result apply_action(t_item it);
            t_result     r;
            int unsigned w;
            int unsigned h;
            int unsigned tx;
            int unsigned ty;
            int unsigned a;
            logic        at_border;
            logic [1:0]  mask;
            r = '0;
            w = cols();
            h = rows();
            case (it.action)
                ACT_OPEN, ACT_QUERY: begin
                    if (it.cell_x >= w || it.cell_y >= h) begin
                        r.out_of_range = 1'b1;
                    end else begin
                        tx = it.cell_x;
                        ty = it.cell_y;
                        case (it.direction)
                            DIR_NORTH: begin
                                at_border = (ty == 0);
                                mask = NORTH_BIT;
                            end
                            DIR_EAST: begin
                                at_border = (tx + 1 >= w);
                                tx = tx + 1;
                                mask = WEST_BIT;
                            end
                            DIR_SOUTH: begin
                                at_border = (ty + 1 >= h);
                                ty = ty + 1;
                                mask = NORTH_BIT;
                            end
                            default: begin
                                at_border = (tx == 0);
                                mask = WEST_BIT;
                            end
                        endcase
                        if (!at_border) begin
                            a = ty * GRID_COLS + tx;
                            if (it.action == ACT_OPEN) passage_mem[a] = passage_mem[a] | mask;
                            r.path_open = ((passage_mem[a] & mask) != 0);
                        end
                    end
                end
                ACT_PLOT: begin
                    if (it.plot_x > 2 * w || it.plot_y > 2 * h) r.out_of_range = 1'b1;
                    else r.pixel = pixel_at(it.plot_x, it.plot_y, w, h);
                end
                default: ;
            endcase
            return r;
        endfunction

        function void note_item(t_item it);
            pending_results.push_back(apply_action(it));
        endfunction

        function void compare_field(string name, integer exp_val, integer got_val);
            if (exp_val !== got_val) begin
                $display("%0t mismatch %s: expected %0d actual %0d",
                         $time, name, exp_val, got_val);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result exp_res;
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result: expected none actual %b", $time, got);
                errors++;
                return;
            end
            exp_res = pending_results.pop_front();
            compare_field("path_open", exp_res.path_open, got.path_open);
            compare_field("pixel", exp_res.pixel, got.pixel);
            compare_field("out_of_range", exp_res.out_of_range, got.out_of_range);
        endfunction
    endclass

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    t_item            i_in_data   = '0;
    logic             i_out_stall = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic             i_cfg_index = CFG_IDX_WIDTH;
    logic [CFG_W-1:0] i_cfg_data  = '0;
    logic             o_in_stall;
    logic             o_out_valid;
    t_result          o_out_data;
    logic             o_cfg_ready;

    passage_scoreboard board;
    int                quiet_cycles = 0;
    int unsigned       stall_mode   = 0;
    int unsigned       stall_left   = 0;

    maze_grid_wall_store_top #(
        .MAX_WIDTH (GRID_COLS),
        .MAX_HEIGHT(GRID_ROWS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // result-side stall: free flow, coin toss, periodic, or mostly stalled
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(30, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= $urandom_range(0, 1);
            2: i_out_stall <= (stall_left % 4 == 0);
            default: i_out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // handshakes are settled mid-cycle; whatever fires here is taken at the next edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && !i_out_stall) board.check_result(o_out_data);
            if ((i_in_valid && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready === 1'b1)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("maze_grid_wall_store_top_test: FAIL");
                    $finish;
                end
            end
        end
    end

    function automatic t_item make_item(logic [1:0] act, logic [5:0] cx, logic [5:0] cy,
                                        logic [1:0] dir, logic [7:0] px, logic [7:0] py);
        t_item it;
        it.action    = act;
        it.cell_x    = cx;
        it.cell_y    = cy;
        it.direction = dir;
        it.plot_x    = px;
        it.plot_y    = py;
        return it;
    endfunction

    function automatic t_item random_item(int unsigned w, int unsigned h);
        t_item       it;
        int unsigned pick;
        it   = t_item'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            it.action = (pick < 35) ? ACT_OPEN : ACT_QUERY;
            it.cell_x = 6'($urandom_range(0, w - 1));
            it.cell_y = 6'($urandom_range(0, h - 1));
        end else if (pick < 88) begin
            it.action = ACT_PLOT;
            it.plot_x = 8'($urandom_range(0, 2 * w));
            it.plot_y = 8'($urandom_range(0, 2 * h));
        end else if (pick < 96) begin
            it.action = 2'($urandom_range(0, 2));
        end else begin
            it.action = ACT_UNKNOWN;
        end
        return it;
    endfunction

    // leaves valid high so that a following transaction goes back to back
    task automatic send_item(t_item it);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(negedge i_clk); while (o_in_stall !== 1'b0);
        board.note_item(it);
        @(posedge i_clk);
    endtask

    task automatic write_regs(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        logic idx;
        for (int k = 0; k < 2; k++) begin
            idx = (k == 0) ? CFG_IDX_WIDTH : CFG_IDX_HEIGHT;
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= (k == 0) ? w : h;
            do @(negedge i_clk); while (o_cfg_ready !== 1'b1);
            board.write_size(idx, (k == 0) ? w : h);
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [CFG_W-1:0] phase_w [NUM_PHASES];
        logic [CFG_W-1:0] phase_h [NUM_PHASES];
        int unsigned      burst_left;
        int unsigned      gap;
        logic             no_gaps;

        board   = new();
        phase_w = '{7'd1, 7'd2, 7'd5, 7'd8, 7'd64, 7'd127, 7'd3, 7'd1, 7'd16, 7'd0};
        phase_h = '{7'd1, 7'd3, 7'd4, 7'd8, 7'd64, 7'd127, 7'd1, 7'd6, 7'd2, 7'd5};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero sizes act as a single cell
        write_regs(7'd0, 7'd0);
        send_item(make_item(ACT_OPEN, 6'd0, 6'd0, DIR_NORTH, 8'd0, 8'd0));
        send_item(make_item(ACT_OPEN, 6'd0, 6'd0, DIR_EAST, 8'd0, 8'd0));
        send_item(make_item(ACT_OPEN, 6'd0, 6'd0, DIR_SOUTH, 8'd0, 8'd0));
        send_item(make_item(ACT_QUERY, 6'd0, 6'd0, DIR_WEST, 8'd0, 8'd0));
        send_item(make_item(ACT_PLOT, 6'd0, 6'd0, DIR_NORTH, 8'd1, 8'd0));
        send_item(make_item(ACT_PLOT, 6'd0, 6'd0, DIR_NORTH, 8'd2, 8'd1));
        send_item(make_item(ACT_PLOT, 6'd0, 6'd0, DIR_NORTH, 8'd1, 8'd2));
        send_item(make_item(ACT_PLOT, 6'd0, 6'd0, DIR_NORTH, 8'd0, 8'd1));
        send_item(make_item(ACT_PLOT, 6'd63, 6'd63, DIR_WEST, 8'd255, 8'd255));
        send_item(make_item(ACT_QUERY, 6'd63, 6'd63, DIR_WEST, 8'd0, 8'd0));
        send_item(make_item(ACT_UNKNOWN, 6'd63, 6'd63, DIR_WEST, 8'd255, 8'd255));
        i_in_valid <= 1'b0;
        wait_drained();

        // oversize width clamps to the maximum
        write_regs(7'd127, 7'd64);
        send_item(make_item(ACT_OPEN, 6'd0, 6'd0, DIR_EAST, 8'd0, 8'd0));
        send_item(make_item(ACT_OPEN, 6'd63, 6'd63, DIR_SOUTH, 8'd0, 8'd0));
        send_item(make_item(ACT_OPEN, 6'd63, 6'd63, DIR_WEST, 8'd0, 8'd0));
        send_item(make_item(ACT_QUERY, 6'd62, 6'd63, DIR_EAST, 8'd0, 8'd0));
        send_item(make_item(ACT_OPEN, 6'd5, 6'd5, DIR_NORTH, 8'd0, 8'd0));
        send_item(make_item(ACT_PLOT, 6'd0, 6'd0, DIR_NORTH, 8'd11, 8'd10));
        send_item(make_item(ACT_PLOT, 6'd0, 6'd0, DIR_NORTH, 8'd128, 8'd128));
        send_item(make_item(ACT_PLOT, 6'd0, 6'd0, DIR_NORTH, 8'd127, 8'd128));
        send_item(make_item(ACT_PLOT, 6'd0, 6'd0, DIR_NORTH, 8'd128, 8'd127));
        send_item(make_item(ACT_PLOT, 6'd0, 6'd0, DIR_NORTH, 8'd0, 8'd3));
        send_item(make_item(ACT_PLOT, 6'd0, 6'd0, DIR_NORTH, 8'd126, 8'd127));
        send_item(make_item(ACT_QUERY, 6'd0, 6'd0, DIR_NORTH, 8'd0, 8'd0));
        send_item(make_item(ACT_OPEN, 6'd63, 6'd0, DIR_EAST, 8'd200, 8'd77));
        i_in_valid <= 1'b0;
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_regs(phase_w[p], phase_h[p]);
            no_gaps    = (p % 3 == 1);
            burst_left = $urandom_range(1, 12);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                send_item(random_item(board.cols(), board.rows()));
                if (p == 4 && i == PHASE_ITEMS / 2) begin
                    // hold off until the store has answered everything
                    i_in_valid <= 1'b0;
                    wait_drained();
                end else if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap        = no_gaps ? 0 : $urandom_range(0, 6);
                    if (gap != 0) begin
                        i_in_valid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end else begin
                    burst_left--;
                end
            end
            i_in_valid <= 1'b0;
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("maze_grid_wall_store_top_test: PASS");
        end else begin
            $display("maze_grid_wall_store_top_test: FAIL");
        end
        $finish;
    end

endmodule

[maze_grid_wall_store_top.f]
rtl/mgws_pkg.sv
rtl/mgws_front.sv
rtl/mgws_queue.sv
rtl/mgws_back.sv
rtl/maze_grid_wall_store_top.sv
verif/maze_grid_wall_store_top_test.sv
